// ===== design/base64_encoder_line_wrap_top_defines.svh =====
// Assertion macros shared by the base64 line-wrap encoder modules.
`ifndef BASE64_ENCODER_LINE_WRAP_TOP_DEFINES_SVH
`define BASE64_ENCODER_LINE_WRAP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define B64LW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("b64lw assertion failed");
`define B64LW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64lw assertion failed");
`else
`define B64LW_ASSERT(lbl, prop)
`define B64LW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/b64lw_pkg.sv =====
// Types, constants and alphabet lookup for the base64 line-wrap encoder.
`default_nettype none

package b64lw_pkg;

  localparam logic [7:0] PadChar     = 8'd61;
  localparam logic [7:0] NewlineChar = 8'd10;

  localparam logic [2:0] PosLastQuad = 3'd3;
  localparam logic [2:0] PosNewline  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // One group as queued between front and back
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  used;
    logic        nl;
  } grp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    priority if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/base64_encoder_line_wrap_top.sv =====
// Top level of the base64 encoder with optional line wrapping.
`default_nettype none

// Base64 encoder, standard alphabet, one message byte per input beat with a
// flag on the final byte. Every third byte, or the final byte, queues one
// group; the back end then sends its four characters ('=' for padding) and a
// newline where the line fills or, with wrapping on, after a padded final
// group. One character leaves per cycle while the output is not stalled, so
// a group gives four output characters, or five with its newline, and the
// single output character register sets this rate. Bytes are taken every
// cycle while the QueueDepth-entry group queue has room. A group's last
// byte writes it into the queue, and its first character is then registered
// in the output character register. quads_per_line is written through
// cfg_we_i/cfg_wdata_i; zero turns wrapping off.
module base64_encoder_line_wrap_top import b64lw_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_item_o
);

  logic push, full, pop, empty;
  grp_t push_data, head;

  b64lw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  b64lw_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  b64lw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== design/b64lw_front.sv =====
// Front end: gathers bytes into groups, tracks the line count, queues groups.
`default_nettype none
`include "base64_encoder_line_wrap_top_defines.svh"

module b64lw_front import b64lw_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output grp_t          push_data_o
);

  logic [15:0] qpl_q, qpl_d;
  logic [15:0] held_bytes_q, held_bytes_d;
  logic [1:0]  held_count_q, held_count_d;
  logic [15:0] qc_q, qc_d;
  logic        accept;
  logic        complete;
  logic        line_full;
  logic [1:0]  have;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign have       = held_count_q + 2'd1;
  assign complete   = (held_count_q == 2'd2);
  assign line_full  = ({1'b0, qc_q} + 17'd1) >= {1'b0, qpl_q};

  always_comb begin
    qpl_d        = cfg_we_i ? cfg_wdata_i : qpl_q;
    held_bytes_d = held_bytes_q;
    held_count_d = held_count_q;
    qc_d         = qc_q;
    push_o       = accept & (complete | in_item_i.last_byte);
    push_data_o  = '0;

    if (complete) begin
      push_data_o.group = {held_bytes_q, in_item_i.data_byte};
      push_data_o.used  = 2'd3;
      push_data_o.nl    = (qpl_q != 16'd0) & line_full;
    end else if (have == 2'd1) begin
      push_data_o.group = {in_item_i.data_byte, 16'd0};
      push_data_o.used  = have;
      push_data_o.nl    = (qpl_q != 16'd0);
    end else begin
      push_data_o.group = {held_bytes_q[7:0], in_item_i.data_byte, 8'd0};
      push_data_o.used  = have;
      push_data_o.nl    = (qpl_q != 16'd0);
    end

    if (accept) begin
      if (push_o) begin
        held_bytes_d = '0;
        held_count_d = '0;
      end else begin
        held_bytes_d = {held_bytes_q[7:0], in_item_i.data_byte};
        held_count_d = have;
      end
      if (in_item_i.last_byte) begin
        qc_d = '0;
      end else if (complete && (qpl_q != 16'd0)) begin
        qc_d = line_full ? 16'd0 : qc_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpl_q        <= '0;
      held_bytes_q <= '0;
      held_count_q <= '0;
      qc_q         <= '0;
    end else begin
      qpl_q        <= qpl_d;
      held_bytes_q <= held_bytes_d;
      held_count_q <= held_count_d;
      qc_q         <= qc_d;
    end
  end

  `B64LW_ASSERT(a_held_count_range, held_count_q != 2'd3)
  `B64LW_ASSERT_NEXT(a_last_clears, accept && in_item_i.last_byte,
                     qc_q == 16'd0 && held_count_q == 2'd0)

endmodule

`default_nettype wire

// ===== design/b64lw_fifo.sv =====
// Short group queue between the front and back ends.
`default_nettype none
`include "base64_encoder_line_wrap_top_defines.svh"

module b64lw_fifo import b64lw_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire grp_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output grp_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `B64LW_ASSERT(a_no_overflow, push_i |-> !full_o)
  `B64LW_ASSERT(a_no_underflow, pop_i |-> !empty_o)
  `B64LW_ASSERT(a_count_bound, count_q <= CntW'(Depth))

endmodule

`default_nettype wire

// ===== design/b64lw_back.sv =====
// Back end: emits the characters of each queued group, one per cycle while the output is not stalled.
`default_nettype none
`include "base64_encoder_line_wrap_top_defines.svh"

module b64lw_back import b64lw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire grp_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_item_o
);

  logic [2:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       load;
  logic [5:0] sextet;
  logic [2:0] final_pos;

  assign load      = ~out_valid_q | ~out_stall_i;
  assign final_pos = head_i.nl ? PosNewline : PosLastQuad;

  always_comb begin
    unique case (pos_q[1:0])
      2'd0:    sextet = head_i.group[23:18];
      2'd1:    sextet = head_i.group[17:12];
      2'd2:    sextet = head_i.group[11:6];
      default: sextet = head_i.group[5:0];
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (load) begin
      if (!q_empty_i) begin
        out_valid_d = 1'b1;
        priority if (pos_q == PosNewline) begin
          out_d.out_char = NewlineChar;
        end else if (pos_q[1:0] > head_i.used) begin
          out_d.out_char = PadChar;
        end else begin
          out_d.out_char = b64_char(sextet);
        end
        out_d.last_char = (pos_q == final_pos);
        if (pos_q == final_pos) begin
          pop_o = 1'b1;
          pos_d = '0;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `B64LW_ASSERT(a_pos_range, pos_q <= PosNewline)
  `B64LW_ASSERT(a_last_rewinds, (out_valid_q && out_q.last_char) |-> pos_q == 3'd0)

endmodule

`default_nettype wire
